>>> rtl/core/ctc_pkg.sv
package ctc_pkg;

    localparam int SUM_W   = 29;
    localparam int CNT_W   = 19;
    localparam int COORD_W = 10;
    localparam int SIZE_W  = 11;
    localparam int IDX_W   = 3;

    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    // one quotient bit per step over the whole dividend
    localparam int DIV_STEPS = SUM_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    localparam logic [IDX_W-1:0] REG_HUE_CENTER    = 3'd0;
    localparam logic [IDX_W-1:0] REG_HUE_TOLERANCE = 3'd1;
    localparam logic [IDX_W-1:0] REG_SAT_CENTER    = 3'd2;
    localparam logic [IDX_W-1:0] REG_SAT_TOLERANCE = 3'd3;
    localparam logic [IDX_W-1:0] REG_FRAME_WIDTH   = 3'd4;
    localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT  = 3'd5;

    localparam logic [7:0]        RST_HUE_CENTER    = 8'd175;
    localparam logic [6:0]        RST_HUE_TOLERANCE = 7'd54;
    localparam logic [7:0]        RST_SAT_CENTER    = 8'd226;
    localparam logic [6:0]        RST_SAT_TOLERANCE = 7'd57;
    localparam logic [SIZE_W-1:0] RST_FRAME_WIDTH   = 11'd640;
    localparam logic [SIZE_W-1:0] RST_FRAME_HEIGHT  = 11'd480;

    typedef struct packed {
        logic acc;    // accumulate the accepted pixel
        logic load;   // frame end: move sums into the divider, clear them
        logic step;   // one divider iteration
        logic emit;   // capture the finished result in the output register
    } t_cmd;

endpackage

>>> rtl/core/ctc_ctrl.sv
module ctc_ctrl
    import ctc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_tvalid,
    input  logic i_s_tlast,
    input  logic i_m_tready,
    output logic o_s_tready,
    output logic o_m_tvalid,
    output t_cmd o_cmd
);

    localparam logic [1:0] ST_ACC  = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIV_STEPS - 1);

    logic [1:0]        r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;
    logic              r_out_valid, n_out_valid;
    logic              accept;
    logic              free;

    assign o_s_tready = (r_state == ST_ACC);
    assign o_m_tvalid = r_out_valid;
    assign accept     = i_s_tvalid && o_s_tready;
    assign free       = !r_out_valid || i_m_tready;

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            ST_ACC: begin
                if (accept) begin
                    o_cmd.acc = 1'b1;
                    if (i_s_tlast) begin
                        o_cmd.load = 1'b1;
                        n_step     = '0;
                        n_state    = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                o_cmd.step = 1'b1;
                n_step     = r_step + 1'b1;
                if (r_step == LAST_STEP) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (free) begin
                    o_cmd.emit  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = ST_ACC;
                end
            end
            default: begin
                n_state = ST_ACC;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_ACC;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

>>> rtl/core/ctc_datapath.sv
module ctc_datapath
    import ctc_pkg::*;
#(
    parameter int MAX_DIM = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    input  logic               i_cfg_we,
    input  logic [IDX_W-1:0]   i_cfg_index,
    input  logic [SIZE_W-1:0]  i_cfg_data,
    input  logic [7:0]         i_hue,
    input  logic [7:0]         i_saturation,
    input  logic [COORD_W-1:0] i_row,
    input  logic [COORD_W-1:0] i_col,
    output logic               o_found,
    output logic [COORD_W-1:0] o_centroid_col,
    output logic [COORD_W-1:0] o_centroid_row,
    output logic [CNT_W-1:0]   o_selected_count
);

    localparam int DIM_W = $clog2(MAX_DIM + 1);
    localparam int BW    = (DIM_W > SIZE_W) ? DIM_W : SIZE_W;
    localparam logic [BW-1:0] DIM_LIM = BW'(MAX_DIM);

    logic [7:0]        r_hue_center, r_sat_center;
    logic [6:0]        r_hue_tol, r_sat_tol;
    logic [SIZE_W-1:0] r_frame_width, r_frame_height;

    logic [SUM_W-1:0]  r_row_sum, r_col_sum, n_row_sum, n_col_sum;
    logic [CNT_W-1:0]  r_cnt, n_cnt;

    logic [SUM_W-1:0]  r_quo_row, r_quo_col;
    logic [CNT_W:0]    r_rem_row, r_rem_col;
    logic [CNT_W-1:0]  r_divisor;

    logic [BW-1:0]     lim_w, lim_h, bound_w, bound_h;
    logic              sampled, hue_ok, sat_ok, hit;
    logic [SUM_W:0]    add_row, add_col;
    logic [CNT_W:0]    trial_row, trial_col, dvs;
    logic              ge_row, ge_col;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hue_center   <= RST_HUE_CENTER;
            r_hue_tol      <= RST_HUE_TOLERANCE;
            r_sat_center   <= RST_SAT_CENTER;
            r_sat_tol      <= RST_SAT_TOLERANCE;
            r_frame_width  <= RST_FRAME_WIDTH;
            r_frame_height <= RST_FRAME_HEIGHT;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_HUE_CENTER:    r_hue_center   <= i_cfg_data[7:0];
                REG_HUE_TOLERANCE: r_hue_tol      <= i_cfg_data[6:0];
                REG_SAT_CENTER:    r_sat_center   <= i_cfg_data[7:0];
                REG_SAT_TOLERANCE: r_sat_tol      <= i_cfg_data[6:0];
                REG_FRAME_WIDTH:   r_frame_width  <= i_cfg_data;
                REG_FRAME_HEIGHT:  r_frame_height <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // clamp to the largest frame, then round down to even
    always_comb begin
        lim_w   = (BW'(r_frame_width) > DIM_LIM) ? DIM_LIM : BW'(r_frame_width);
        lim_h   = (BW'(r_frame_height) > DIM_LIM) ? DIM_LIM : BW'(r_frame_height);
        bound_w = {lim_w[BW-1:1], 1'b0};
        bound_h = {lim_h[BW-1:1], 1'b0};
    end

    assign sampled = !i_row[0] && !i_col[0] &&
                     (BW'(i_row) < bound_h) && (BW'(i_col) < bound_w);

    // x in [c - t, c + t]  <=>  x + t >= c and x <= c + t
    assign hue_ok = ({1'b0, i_hue} + {2'b0, r_hue_tol} >= {1'b0, r_hue_center}) &&
                    ({1'b0, i_hue} <= {1'b0, r_hue_center} + {2'b0, r_hue_tol});
    assign sat_ok = ({1'b0, i_saturation} + {2'b0, r_sat_tol} >= {1'b0, r_sat_center}) &&
                    ({1'b0, i_saturation} <= {1'b0, r_sat_center} + {2'b0, r_sat_tol});

    assign hit = sampled && hue_ok && sat_ok && (r_cnt != CNT_MAX);

    always_comb begin
        add_row   = {1'b0, r_row_sum} + (SUM_W + 1)'(i_row);
        add_col   = {1'b0, r_col_sum} + (SUM_W + 1)'(i_col);
        n_row_sum = r_row_sum;
        n_col_sum = r_col_sum;
        n_cnt     = r_cnt;
        if (hit) begin
            n_row_sum = add_row[SUM_W] ? SUM_MAX : add_row[SUM_W-1:0];
            n_col_sum = add_col[SUM_W] ? SUM_MAX : add_col[SUM_W-1:0];
            n_cnt     = r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_sum <= '0;
            r_col_sum <= '0;
            r_cnt     <= '0;
        end else if (i_cmd.load) begin
            r_row_sum <= '0;
            r_col_sum <= '0;
            r_cnt     <= '0;
        end else if (i_cmd.acc) begin
            r_row_sum <= n_row_sum;
            r_col_sum <= n_col_sum;
            r_cnt     <= n_cnt;
        end
    end

    // restoring divider, both means side by side
    always_comb begin
        dvs       = {1'b0, r_divisor};
        trial_row = {r_rem_row[CNT_W-1:0], r_quo_row[SUM_W-1]};
        trial_col = {r_rem_col[CNT_W-1:0], r_quo_col[SUM_W-1]};
        ge_row    = (trial_row >= dvs);
        ge_col    = (trial_col >= dvs);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_quo_row <= n_row_sum;
            r_quo_col <= n_col_sum;
            r_rem_row <= '0;
            r_rem_col <= '0;
            r_divisor <= n_cnt;
        end else if (i_cmd.step) begin
            r_quo_row <= {r_quo_row[SUM_W-2:0], ge_row};
            r_quo_col <= {r_quo_col[SUM_W-2:0], ge_col};
            r_rem_row <= ge_row ? (trial_row - dvs) : trial_row;
            r_rem_col <= ge_col ? (trial_col - dvs) : trial_col;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_found          <= (r_divisor != '0);
            o_centroid_row   <= (r_divisor != '0) ? r_quo_row[COORD_W-1:0] : '0;
            o_centroid_col   <= (r_divisor != '0) ? r_quo_col[COORD_W-1:0] : '0;
            o_selected_count <= r_divisor;
        end
    end

endmodule

>>> rtl/core/color_threshold_centroid_unit.sv
// Channel   Dir  Handshake                 Payload
// s_axis    in   i_s_tvalid / o_s_tready   tdata pixel, tlast end of frame
// m_axis    out  o_m_tvalid / i_m_tready   tdata centroid and count, tuser found
// cfg       in   i_cfg_valid / o_cfg_ready index and register value
//
// One pixel beat per cycle within a frame. The beat marked tlast starts a
// shared 29-step restoring divide (one quotient bit per cycle for both means);
// the result is then loaded into the output register once that register is free,
// and the next frame's first pixel is taken in the cycle after that load.
// The output register holds a finished result while pixels of the next frame
// flow in; a second frame end waits in the divider until that beat is taken.
// Reset is synchronous, active low; config registers return to default values.
module color_threshold_centroid_unit
    import ctc_pkg::*;
#(
    parameter int MAX_DIM = 1024
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    // [7:0] hue, [15:8] saturation, [25:16] row, [35:26] col, [39:36] zero
    input  logic [39:0]       i_s_tdata,
    input  logic              i_s_tlast,
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    // [9:0] centroid_col, [19:10] centroid_row, [38:20] selected_count, [39] zero
    output logic [39:0]       o_m_tdata,
    // [0] found
    output logic              o_m_tuser,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [IDX_W-1:0]  i_cfg_index,
    input  logic [SIZE_W-1:0] i_cfg_data
);

    t_cmd               cmd;
    logic [COORD_W-1:0] centroid_col, centroid_row;
    logic [CNT_W-1:0]   selected_count;

    // registers accept a write on any cycle
    assign o_cfg_ready = 1'b1;

    ctc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_s_tlast  (i_s_tlast),
        .i_m_tready (i_m_tready),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_cmd      (cmd)
    );

    ctc_datapath #(
        .MAX_DIM (MAX_DIM)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_cfg_we         (i_cfg_valid && o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_hue            (i_s_tdata[7:0]),
        .i_saturation     (i_s_tdata[15:8]),
        .i_row            (i_s_tdata[25:16]),
        .i_col            (i_s_tdata[35:26]),
        .o_found          (o_m_tuser),
        .o_centroid_col   (centroid_col),
        .o_centroid_row   (centroid_row),
        .o_selected_count (selected_count)
    );

    assign o_m_tdata = {1'b0, selected_count, centroid_row, centroid_col};

    // a frame end stops the pixel stream while the divide runs
    a_eof_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && i_s_tlast) |=> !o_s_tready)
        else $error("pixel accepted right after frame end");

    // found tracks a nonzero count
    a_found_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tuser == (o_m_tdata[38:20] != '0)))
        else $error("found disagrees with selected count");

    // an empty frame reports a zero centroid
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser) |-> (o_m_tdata[19:0] == '0))
        else $error("empty frame with nonzero centroid");

endmodule
